// ===== hdl/detector_frame_deframer_core_defines.svh =====
// ----------------------------------------------------------------------------
// Detector frame deframer - shared assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DETECTOR_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define DETECTOR_FRAME_DEFRAMER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define DFD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("dfd assertion failed");
// checked on every edge, reset included
`define DFD_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("dfd assertion failed");
`else
`define DFD_ASSERT(label, prop)
`define DFD_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== hdl/dfd_pkg.sv =====
// ----------------------------------------------------------------------------
// dfd_pkg
// Types and constants shared by the detector frame deframer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dfd_pkg;

  localparam int COLS = 1024;
  localparam int ROWS = 1024;

  localparam int WORD_W  = 16;
  localparam int HDR_W   = 12;
  localparam int TAG_W   = 4;
  localparam int FULL_W  = 24;
  localparam int ROW_W   = 12;
  localparam int FRAME_W = 16;
  localparam int ADDR_W  = 22;
  // column counter must hold COLS itself
  localparam int COL_W   = $clog2(COLS + 1);
  localparam int IDX_W   = (COLS > 1) ? $clog2(COLS) : 1;

  localparam logic [WORD_W-1:0] START_MARKER_RST = 16'd35981;
  localparam logic [WORD_W-1:0] END_MARKER_RST   = 16'd36495;

  localparam logic [COL_W-1:0] COLS_C     = COL_W'(COLS);
  localparam logic [ROW_W-1:0] LAST_ROW_C = ROW_W'(ROWS - 1);

  localparam logic [TAG_W-1:0] TAG_TIME_HI = 4'd15;
  localparam logic [TAG_W-1:0] TAG_TIME_LO = 4'd14;
  localparam logic [TAG_W-1:0] TAG_ROW     = 4'd13;
  localparam logic [TAG_W-1:0] TAG_T0_HI   = 4'd12;
  localparam logic [TAG_W-1:0] TAG_T0_LO   = 4'd11;
  localparam logic [TAG_W-1:0] TAG_T1_HI   = 4'd10;
  localparam logic [TAG_W-1:0] TAG_T1_LO   = 4'd9;

  // configuration register indexes
  localparam logic CFG_START = 1'b0;
  localparam logic CFG_END   = 1'b1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_TIME_HI = 4'd1,
    PH_TIME_LO = 4'd2,
    PH_ROW     = 4'd3,
    PH_T0_HI   = 4'd4,
    PH_T0_LO   = 4'd5,
    PH_T1_HI   = 4'd6,
    PH_T1_LO   = 4'd7,
    PH_PIXELS  = 4'd8
  } phase_t;

  typedef enum logic {
    KIND_PIXEL   = 1'b0,
    KIND_ROW_END = 1'b1
  } kind_t;

  // one classified word waiting for the back end
  typedef struct packed {
    kind_t              kind;
    logic [WORD_W-1:0]  pixel_value;
    logic [IDX_W-1:0]   column;
    logic [ROW_W-1:0]   row;
    logic [FULL_W-1:0]  time_stamp;
    logic [FULL_W-1:0]  temp_zero;
    logic [FULL_W-1:0]  temp_one;
    logic [FRAME_W-1:0] frame;
    logic               frame_complete;
  } q_entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

endpackage

// ===== hdl/detector_frame_deframer_core.sv =====
// ----------------------------------------------------------------------------
// detector_frame_deframer_core
// Telemetry deframer: turns a 16-bit word stream into pixel and row-end words.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_word_in) takes one stream word per
// cycle while in_stall is low. The walker hunts the start marker, gathers
// the tagged time, row and temperature header words, then passes COLS pixel
// words and a closing end marker. Each pixel gives one result word carrying
// its address row*COLS+column plus the latest header readings; the end
// marker gives a row-end word, frame_complete set on the last row.
// Throughput: one word per cycle while in_stall is low.
// Path: an accepted word is written into the queue, then into the output
// register when that register is empty or its word is taken (out_stall low).
// A 4-entry queue sits between walker and output register; in_stall rises
// only when that queue is full, so a stalled receiver backs up into the
// input after four pending results plus the one held at the output.
// Config port (cfg_valid/cfg_ready/cfg_index/cfg_data) writes start marker
// (index 0) and end marker (index 1); cfg_ready is always high.
// Reset (rst_n low, synchronous) returns the walker to the hunt, clears all
// readings, counters and the queue, and restores the default markers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module detector_frame_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_word_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [15:0] out_pixel_value,
  output logic [21:0] out_pixel_address,
  output logic [11:0] out_row_number,
  output logic [23:0] out_time_stamp,
  output logic [23:0] out_temp_zero,
  output logic [23:0] out_temp_one,
  output logic [15:0] out_frame_seq,
  output logic        out_frame_complete,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import dfd_pkg::*;

  logic     accept;
  logic     q_full;
  logic     q_valid;
  logic     q_push;
  logic     q_pop;
  q_ctrl_t  q_ctrl;
  q_entry_t wr_entry, rd_entry;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !in_stall;
  assign q_ctrl    = '{push: q_push, pop: q_pop};

  dfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .word_in   (in_word_in),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (q_push),
    .entry     (wr_entry)
  );

  dfd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (q_ctrl),
    .wr_entry (wr_entry),
    .rd_entry (rd_entry),
    .rd_valid (q_valid),
    .full     (q_full)
  );

  dfd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_entry            (rd_entry),
    .pop                (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_pixel_value    (out_pixel_value),
    .out_pixel_address  (out_pixel_address),
    .out_row_number     (out_row_number),
    .out_time_stamp     (out_time_stamp),
    .out_temp_zero      (out_temp_zero),
    .out_temp_one       (out_temp_one),
    .out_frame_seq      (out_frame_seq),
    .out_frame_complete (out_frame_complete)
  );

endmodule

// ===== hdl/dfd_front.sv =====
// ----------------------------------------------------------------------------
// dfd_front
// Packet walker: hunts the start marker, assembles header readings and
// classifies pixel and end-marker words into queue entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfd_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept,
  input  logic [15:0]             word_in,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [15:0]             cfg_data,
  output logic                    push,
  output dfd_pkg::q_entry_t       entry
);
  import dfd_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [HDR_W-1:0]   time_hi_r, time_hi_nxt;
  logic [FULL_W-1:0]  time_r, time_nxt;
  logic [HDR_W-1:0]   t0_hi_r, t0_hi_nxt;
  logic [FULL_W-1:0]  t0_r, t0_nxt;
  logic [HDR_W-1:0]   t1_hi_r, t1_hi_nxt;
  logic [FULL_W-1:0]  t1_r, t1_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic [WORD_W-1:0]  start_r, end_r;

  logic [TAG_W-1:0] tag;
  logic [HDR_W-1:0] low;

  assign tag = word_in[WORD_W-1 -: TAG_W];
  assign low = word_in[HDR_W-1:0];

  always_comb begin
    phase_nxt   = phase_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    time_hi_nxt = time_hi_r;
    time_nxt    = time_r;
    t0_hi_nxt   = t0_hi_r;
    t0_nxt      = t0_r;
    t1_hi_nxt   = t1_hi_r;
    t1_nxt      = t1_r;
    frame_nxt   = frame_r;
    push        = 1'b0;

    entry.kind           = KIND_PIXEL;
    entry.pixel_value    = word_in;
    entry.column         = col_r[IDX_W-1:0];
    entry.row            = row_r;
    entry.time_stamp     = time_r;
    entry.temp_zero      = t0_r;
    entry.temp_one       = t1_r;
    entry.frame          = frame_r;
    entry.frame_complete = 1'b0;

    if (accept) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (word_in == start_r) phase_nxt = PH_TIME_HI;
        end
        PH_TIME_HI: begin
          if (tag == TAG_TIME_HI) begin
            time_hi_nxt = low;
            phase_nxt   = PH_TIME_LO;
          end
        end
        PH_TIME_LO: begin
          if (tag == TAG_TIME_LO) begin
            time_nxt  = {time_hi_r, low};
            phase_nxt = PH_ROW;
          end
        end
        PH_ROW: begin
          if (tag == TAG_ROW) begin
            row_nxt = low;
            if (low == '0) frame_nxt = frame_r + 1'b1;
            col_nxt   = '0;
            phase_nxt = PH_T0_HI;
          end
        end
        PH_T0_HI: begin
          if (tag == TAG_T0_HI) begin
            t0_hi_nxt = low;
            phase_nxt = PH_T0_LO;
          end
        end
        PH_T0_LO: begin
          if (tag == TAG_T0_LO) begin
            t0_nxt    = {t0_hi_r, low};
            phase_nxt = PH_T1_HI;
          end
        end
        PH_T1_HI: begin
          if (tag == TAG_T1_HI) begin
            t1_hi_nxt = low;
            phase_nxt = PH_T1_LO;
          end
        end
        PH_T1_LO: begin
          if (tag == TAG_T1_LO) begin
            t1_nxt    = {t1_hi_r, low};
            phase_nxt = PH_PIXELS;
          end
        end
        PH_PIXELS: begin
          // markers inside the pixel run are plain pixels
          if (col_r < COLS_C) begin
            col_nxt = col_r + 1'b1;
            push    = 1'b1;
          end else if (word_in == end_r) begin
            col_nxt              = '0;
            phase_nxt            = PH_HUNT;
            push                 = 1'b1;
            entry.kind           = KIND_ROW_END;
            entry.pixel_value    = '0;
            entry.column         = '0;
            entry.frame_complete = (row_r == LAST_ROW_C);
          end
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      col_r     <= '0;
      row_r     <= '0;
      time_hi_r <= '0;
      time_r    <= '0;
      t0_hi_r   <= '0;
      t0_r      <= '0;
      t1_hi_r   <= '0;
      t1_r      <= '0;
      frame_r   <= '0;
      start_r   <= START_MARKER_RST;
      end_r     <= END_MARKER_RST;
    end else begin
      phase_r   <= phase_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      time_hi_r <= time_hi_nxt;
      time_r    <= time_nxt;
      t0_hi_r   <= t0_hi_nxt;
      t0_r      <= t0_nxt;
      t1_hi_r   <= t1_hi_nxt;
      t1_r      <= t1_nxt;
      frame_r   <= frame_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_START: start_r <= cfg_data;
          CFG_END:   end_r   <= cfg_data;
          default:   ;
        endcase
      end
    end
  end

endmodule

// ===== hdl/dfd_queue.sv =====
// ----------------------------------------------------------------------------
// dfd_queue
// Short entry queue between the packet walker and the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "detector_frame_deframer_core_defines.svh"

module dfd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  dfd_pkg::q_ctrl_t  ctrl,
  input  dfd_pkg::q_entry_t wr_entry,
  output dfd_pkg::q_entry_t rd_entry,
  output logic              rd_valid,
  output logic              full
);
  import dfd_pkg::*;

  q_entry_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  count_r, count_nxt;

  assign rd_valid = (count_r != '0);
  assign full     = (count_r == QCNT_W'(QDEPTH));
  assign rd_entry = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (ctrl.push && !ctrl.pop) count_nxt = count_r + 1'b1;
    else if (!ctrl.push && ctrl.pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) mem_r[wr_ptr_r] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (ctrl.push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (ctrl.pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  `DFD_ASSERT(a_no_push_full, !(ctrl.push && full && !ctrl.pop))
  `DFD_ASSERT(a_no_pop_empty, ctrl.pop |-> rd_valid)
  `DFD_ASSERT(a_count_bound, count_r <= QCNT_W'(QDEPTH))
  `DFD_ASSERT(a_ptr_gap, QPTR_W'(wr_ptr_r - rd_ptr_r) == count_r[QPTR_W-1:0])
  `DFD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (count_r == '0))

endmodule

// ===== hdl/dfd_back.sv =====
// ----------------------------------------------------------------------------
// dfd_back
// Output stage: forms pixel addresses and holds the result word until the
// receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  dfd_pkg::q_entry_t q_entry,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_kind,
  output logic [15:0]       out_pixel_value,
  output logic [21:0]       out_pixel_address,
  output logic [11:0]       out_row_number,
  output logic [23:0]       out_time_stamp,
  output logic [23:0]       out_temp_zero,
  output logic [23:0]       out_temp_one,
  output logic [15:0]       out_frame_seq,
  output logic              out_frame_complete
);
  import dfd_pkg::*;

  logic              valid_r;
  q_entry_t          hold_r;
  logic [ADDR_W-1:0] addr_r, addr_nxt;

  // row-end entries carry row but no address
  always_comb begin
    addr_nxt = ADDR_W'(q_entry.row) * ADDR_W'(COLS) + ADDR_W'(q_entry.column);
    if (q_entry.kind == KIND_ROW_END) addr_nxt = '0;
  end

  assign pop = q_valid && (!valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || !out_stall) begin
      valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      hold_r <= q_entry;
      addr_r <= addr_nxt;
    end
  end

  assign out_valid          = valid_r;
  assign out_kind           = hold_r.kind;
  assign out_pixel_value    = hold_r.pixel_value;
  assign out_pixel_address  = addr_r;
  assign out_row_number     = hold_r.row;
  assign out_time_stamp     = hold_r.time_stamp;
  assign out_temp_zero      = hold_r.temp_zero;
  assign out_temp_one       = hold_r.temp_one;
  assign out_frame_seq      = hold_r.frame;
  assign out_frame_complete = hold_r.frame_complete;

endmodule
